### rtl/core/fchc_pkg.sv
// shared types, constants and helpers for the fan curve controller
`timescale 1ns / 1ps
`default_nettype none

package fchc_pkg;

    localparam int TEMP_W     = 12;
    localparam int DUTY_W     = 8;
    localparam int RUN_W      = 16;
    localparam int TIME_W     = 32;
    localparam int PCT_W      = 7;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 16;
    localparam int S_DATA_W   = 56;
    localparam int M_DATA_W   = 16;

    // interpolation datapath widths
    localparam int SPAN_W     = TEMP_W + 1;
    localparam int DIFF_W     = DUTY_W;
    localparam int PROD_W     = SPAN_W + DIFF_W;
    localparam int X_W        = PROD_W + 2;
    localparam int DIV_BITS   = 20;
    localparam int CNT_W      = $clog2(DIV_BITS + 1);
    localparam int QS_W       = 10;

    localparam int OP_W       = 3;
    localparam int COND_W     = 3;
    localparam int STEP_W     = 3;
    localparam int DSEL_W     = 3;

    // register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_OFF_TEMP      = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_ON_TEMP       = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_FULL_TEMP     = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_THROTTLE_TEMP = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_FLOOR_DUTY    = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_CEILING_DUTY  = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] REG_MIN_RUN_MS    = 3'd6;

    localparam logic signed [TEMP_W-1:0] OFF_TEMP_RST      = 12'sd400;
    localparam logic signed [TEMP_W-1:0] ON_TEMP_RST       = 12'sd450;
    localparam logic signed [TEMP_W-1:0] FULL_TEMP_RST     = 12'sd800;
    localparam logic signed [TEMP_W-1:0] THROTTLE_TEMP_RST = 12'sd900;
    localparam logic [DUTY_W-1:0]        FLOOR_DUTY_RST    = 8'd20;
    localparam logic [DUTY_W-1:0]        CEILING_DUTY_RST  = 8'd100;
    localparam logic [RUN_W-1:0]         MIN_RUN_MS_RST    = 16'd30000;

    localparam logic [PCT_W-1:0] PCT_MAX = 7'd100;

    // datapath operations
    localparam logic [OP_W-1:0] OP_LOAD  = 3'd0;
    localparam logic [OP_W-1:0] OP_MAX   = 3'd1;
    localparam logic [OP_W-1:0] OP_STATE = 3'd2;
    localparam logic [OP_W-1:0] OP_MUL   = 3'd3;
    localparam logic [OP_W-1:0] OP_DIV   = 3'd4;
    localparam logic [OP_W-1:0] OP_FIN   = 3'd5;
    localparam logic [OP_W-1:0] OP_PUSH  = 3'd6;
    localparam logic [OP_W-1:0] OP_NOP   = 3'd7;

    // jump conditions
    localparam logic [COND_W-1:0] COND_NEVER    = 3'd0;
    localparam logic [COND_W-1:0] COND_ALWAYS   = 3'd1;
    localparam logic [COND_W-1:0] COND_NO_REQ   = 3'd2;
    localparam logic [COND_W-1:0] COND_SKIP_DIV = 3'd3;
    localparam logic [COND_W-1:0] COND_DIV_MORE = 3'd4;
    localparam logic [COND_W-1:0] COND_OUT_FREE = 3'd5;

    // duty source picked by the hysteresis step
    localparam logic [DSEL_W-1:0] DSEL_ZERO  = 3'd0;
    localparam logic [DSEL_W-1:0] DSEL_LO    = 3'd1;
    localparam logic [DSEL_W-1:0] DSEL_HI    = 3'd2;
    localparam logic [DSEL_W-1:0] DSEL_CURVE = 3'd3;
    localparam logic [DSEL_W-1:0] DSEL_FAULT = 3'd4;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [COND_W-1:0] cond;
        logic [STEP_W-1:0] target;
    } t_uword;

    typedef struct packed {
        logic skip_div;
        logic div_more;
    } t_dp_stat;

    typedef struct packed {
        logic     req;
        t_dp_stat dp;
        logic     out_free;
    } t_seq_stat;

    typedef struct packed {
        logic signed [TEMP_W-1:0] off_temp;
        logic signed [TEMP_W-1:0] on_temp;
        logic signed [TEMP_W-1:0] full_temp;
        logic signed [TEMP_W-1:0] throttle_temp;
        logic [DUTY_W-1:0]        floor_duty;
        logic [DUTY_W-1:0]        ceiling_duty;
        logic [RUN_W-1:0]         min_run_ms;
    } t_cfg;

    typedef struct packed {
        logic [PCT_W-1:0] fan_duty;
        logic             fan_running;
        logic             data_fault;
        logic             throttle_warn;
    } t_result;

    function automatic logic [PCT_W-1:0] pct_limit(input logic [DUTY_W-1:0] v);
        logic [PCT_W-1:0] r;
        r = (v > {1'b0, PCT_MAX}) ? PCT_MAX : v[PCT_W-1:0];
        return r;
    endfunction

endpackage

`default_nettype wire

### rtl/core/fchc_seq.sv
// microcode sequencer: program table, step counter and jump logic
`timescale 1ns / 1ps
`default_nettype none

module fchc_seq (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  fchc_pkg::t_seq_stat      i_stat,
    output logic [fchc_pkg::OP_W-1:0] o_op
);
    import fchc_pkg::*;

    localparam logic [STEP_W-1:0] STEP_IDLE  = 3'd0;
    localparam logic [STEP_W-1:0] STEP_MAX   = 3'd1;
    localparam logic [STEP_W-1:0] STEP_STATE = 3'd2;
    localparam logic [STEP_W-1:0] STEP_MUL   = 3'd3;
    localparam logic [STEP_W-1:0] STEP_DIV   = 3'd4;
    localparam logic [STEP_W-1:0] STEP_FIN   = 3'd5;
    localparam logic [STEP_W-1:0] STEP_PUSH  = 3'd6;
    localparam logic [STEP_W-1:0] STEP_WAIT  = 3'd7;

    localparam t_uword PROG [0:(1<<STEP_W)-1] = '{
        '{OP_LOAD,  COND_NO_REQ,   STEP_IDLE},
        '{OP_MAX,   COND_NEVER,    STEP_IDLE},
        '{OP_STATE, COND_SKIP_DIV, STEP_FIN},
        '{OP_MUL,   COND_NEVER,    STEP_IDLE},
        '{OP_DIV,   COND_DIV_MORE, STEP_DIV},
        '{OP_FIN,   COND_NEVER,    STEP_IDLE},
        '{OP_PUSH,  COND_OUT_FREE, STEP_IDLE},
        '{OP_NOP,   COND_ALWAYS,   STEP_PUSH}
    };

    logic [STEP_W-1:0] r_step;
    logic [STEP_W-1:0] n_step;
    t_uword            uword;
    logic              jump;

    assign uword = PROG[r_step];
    assign o_op  = uword.op;

    always_comb begin
        unique case (uword.cond)
            COND_NEVER:    jump = 1'b0;
            COND_ALWAYS:   jump = 1'b1;
            COND_NO_REQ:   jump = !i_stat.req;
            COND_SKIP_DIV: jump = i_stat.dp.skip_div;
            COND_DIV_MORE: jump = i_stat.dp.div_more;
            COND_OUT_FREE: jump = i_stat.out_free;
            default:       jump = 1'b0;
        endcase
        n_step = jump ? uword.target : r_step + STEP_W'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= STEP_IDLE;
        end else begin
            r_step <= n_step;
        end
    end

endmodule

`default_nettype wire

### rtl/core/fchc_dp.sv
// datapath: hysteresis state, curve multiply, restoring divider and duty select
`timescale 1ns / 1ps
`default_nettype none

module fchc_dp (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic [fchc_pkg::OP_W-1:0]            i_op,
    input  logic                                 i_load,
    input  fchc_pkg::t_cfg                       i_cfg,
    input  logic signed [fchc_pkg::TEMP_W-1:0]   i_skin_temp,
    input  logic signed [fchc_pkg::TEMP_W-1:0]   i_plate_temp,
    input  logic                                 i_temps_ok,
    input  logic [fchc_pkg::TIME_W-1:0]          i_now_ms,
    output fchc_pkg::t_dp_stat                   o_stat,
    output fchc_pkg::t_result                    o_result
);
    import fchc_pkg::*;

    // request payload
    logic signed [TEMP_W-1:0] r_skin, n_skin;
    logic signed [TEMP_W-1:0] r_plate, n_plate;
    logic                     r_ok, n_ok;
    logic [TIME_W-1:0]        r_now, n_now;
    logic signed [TEMP_W-1:0] r_c, n_c;

    // controller state
    logic                     r_fan_on, n_fan_on;
    logic [TIME_W-1:0]        r_start, n_start;
    logic                     r_hold, n_hold;

    // per-request working registers
    logic [DSEL_W-1:0]        r_dsel, n_dsel;
    logic                     r_warn, n_warn;
    logic                     r_fault, n_fault;
    logic signed [SPAN_W-1:0] r_d, n_d;
    logic signed [SPAN_W-1:0] r_span, n_span;
    logic                     r_neg, n_neg;
    logic [DIV_BITS-1:0]      r_quo, n_quo;
    logic [SPAN_W-1:0]        r_rem, n_rem;
    logic [SPAN_W-1:0]        r_dvs, n_dvs;
    logic [CNT_W-1:0]         r_cnt, n_cnt;
    logic [PCT_W-1:0]         r_duty, n_duty;

    logic signed [TEMP_W-1:0] off_t, on_t, full_t, thr_t;
    logic [PCT_W-1:0]         lo, hi;
    logic [TIME_W-1:0]        elapsed;
    logic                     held;
    logic                     st_fan;
    logic [TIME_W-1:0]        st_start;
    logic                     st_hold;
    logic [DSEL_W-1:0]        st_dsel;
    logic signed [DIFF_W-1:0] diff_hl;
    logic signed [PROD_W-1:0] prod;
    logic signed [X_W-1:0]    x_num;
    logic [X_W-1:0]           x_mag;
    logic [SPAN_W:0]          trial;
    logic                     ge;
    logic [SPAN_W:0]          trial_sub;
    logic signed [QS_W-1:0]   qv, sq, q, lo_s, hi_s;
    logic [PCT_W-1:0]         curve_duty;

    assign off_t  = i_cfg.off_temp;
    assign on_t   = i_cfg.on_temp;
    assign full_t = i_cfg.full_temp;
    assign thr_t  = i_cfg.throttle_temp;
    assign lo     = pct_limit(i_cfg.floor_duty);
    assign hi     = pct_limit(i_cfg.ceiling_duty);

    // hysteresis with minimum run time, elapsed time wraps mod 2^32
    always_comb begin
        elapsed  = r_now - r_start;
        held     = r_hold && (elapsed < {{(TIME_W-RUN_W){1'b0}}, i_cfg.min_run_ms});
        st_fan   = r_fan_on;
        st_start = r_start;
        st_hold  = r_hold;
        if (!r_fan_on) begin
            if (r_c >= on_t) begin
                st_fan   = 1'b1;
                st_start = r_now;
                st_hold  = 1'b1;
            end
        end else begin
            if (r_c <= off_t && !held) begin
                st_fan = 1'b0;
            end
            if (!held) begin
                st_hold = 1'b0;
            end
        end
        priority if (!r_ok) begin
            st_dsel = DSEL_FAULT;
        end else if (!st_fan) begin
            st_dsel = DSEL_ZERO;
        end else if (full_t <= on_t) begin
            st_dsel = DSEL_HI;
        end else if (r_c <= on_t) begin
            st_dsel = DSEL_LO;
        end else if (r_c >= full_t) begin
            st_dsel = DSEL_HI;
        end else begin
            st_dsel = DSEL_CURVE;
        end
    end

    // numerator 2*(c-on)*(hi-lo) + span over 2*span, the rounded quotient of (c-on)*(hi-lo)/span
    assign diff_hl = $signed({1'b0, hi}) - $signed({1'b0, lo});
    assign prod    = PROD_W'(r_d) * PROD_W'(diff_hl);
    assign x_num   = (X_W'(prod) <<< 1) + X_W'(r_span);
    assign x_mag   = x_num[X_W-1] ? X_W'(-x_num) : X_W'(x_num);

    assign trial     = {r_rem, r_quo[DIV_BITS-1]};
    assign ge        = trial >= {1'b0, r_dvs};
    assign trial_sub = trial - {1'b0, r_dvs};

    // signed quotient is within +-100, low byte is enough
    always_comb begin
        qv   = {{(QS_W-DUTY_W){1'b0}}, r_quo[DUTY_W-1:0]};
        sq   = r_neg ? -qv : qv;
        lo_s = $signed({{(QS_W-PCT_W){1'b0}}, lo});
        hi_s = $signed({{(QS_W-PCT_W){1'b0}}, hi});
        q    = lo_s + sq;
        priority if (q < lo_s) begin
            curve_duty = lo;
        end else if (q > hi_s) begin
            curve_duty = hi;
        end else begin
            curve_duty = q[PCT_W-1:0];
        end
    end

    always_comb begin
        n_skin   = r_skin;
        n_plate  = r_plate;
        n_ok     = r_ok;
        n_now    = r_now;
        n_c      = r_c;
        n_fan_on = r_fan_on;
        n_start  = r_start;
        n_hold   = r_hold;
        n_dsel   = r_dsel;
        n_warn   = r_warn;
        n_fault  = r_fault;
        n_d      = r_d;
        n_span   = r_span;
        n_neg    = r_neg;
        n_quo    = r_quo;
        n_rem    = r_rem;
        n_dvs    = r_dvs;
        n_cnt    = r_cnt;
        n_duty   = r_duty;
        unique case (i_op)
            OP_LOAD: begin
                if (i_load) begin
                    n_skin  = i_skin_temp;
                    n_plate = i_plate_temp;
                    n_ok    = i_temps_ok;
                    n_now   = i_now_ms;
                end
            end
            OP_MAX: begin
                n_c = (r_skin >= r_plate) ? r_skin : r_plate;
            end
            OP_STATE: begin
                // invalid data leaves the state alone
                if (r_ok) begin
                    n_fan_on = st_fan;
                    n_start  = st_start;
                    n_hold   = st_hold;
                end
                n_dsel  = st_dsel;
                n_warn  = r_ok && (r_c >= thr_t);
                n_fault = !r_ok;
                n_d     = $signed({r_c[TEMP_W-1], r_c}) - $signed({on_t[TEMP_W-1], on_t});
                n_span  = $signed({full_t[TEMP_W-1], full_t})
                          - $signed({on_t[TEMP_W-1], on_t});
            end
            OP_MUL: begin
                n_neg = x_num[X_W-1];
                n_quo = x_mag[DIV_BITS-1:0];
                n_rem = '0;
                n_dvs = {r_span[SPAN_W-2:0], 1'b0};
                n_cnt = CNT_W'(DIV_BITS);
            end
            OP_DIV: begin
                n_rem = ge ? trial_sub[SPAN_W-1:0] : trial[SPAN_W-1:0];
                n_quo = {r_quo[DIV_BITS-2:0], ge};
                n_cnt = r_cnt - CNT_W'(1);
            end
            OP_FIN: begin
                unique case (r_dsel)
                    DSEL_ZERO:  n_duty = '0;
                    DSEL_LO:    n_duty = lo;
                    DSEL_HI:    n_duty = hi;
                    DSEL_CURVE: n_duty = curve_duty;
                    DSEL_FAULT: n_duty = PCT_MAX;
                    default:    n_duty = '0;
                endcase
            end
            OP_PUSH: begin
            end
            OP_NOP: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fan_on <= 1'b0;
            r_start  <= '0;
            r_hold   <= 1'b0;
            r_cnt    <= '0;
        end else begin
            r_fan_on <= n_fan_on;
            r_start  <= n_start;
            r_hold   <= n_hold;
            r_cnt    <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_skin  <= n_skin;
        r_plate <= n_plate;
        r_ok    <= n_ok;
        r_now   <= n_now;
        r_c     <= n_c;
        r_dsel  <= n_dsel;
        r_warn  <= n_warn;
        r_fault <= n_fault;
        r_d     <= n_d;
        r_span  <= n_span;
        r_neg   <= n_neg;
        r_quo   <= n_quo;
        r_rem   <= n_rem;
        r_dvs   <= n_dvs;
        r_duty  <= n_duty;
    end

    assign o_stat.skip_div = (st_dsel != DSEL_CURVE);
    assign o_stat.div_more = (r_cnt != CNT_W'(1));

    assign o_result.fan_duty      = r_duty;
    assign o_result.fan_running   = r_fault || r_fan_on;
    assign o_result.data_fault    = r_fault;
    assign o_result.throttle_warn = r_warn;

endmodule

`default_nettype wire

### rtl/core/fan_curve_hysteresis_controller.sv
// the divide steps run only on the interpolation path, other results go straight to duty select
// one request at a time: the next is accepted after the result is pushed, which waits on output stall
// the interpolation time is set by the 20-step restoring divider, one quotient bit per cycle
// the output register lets a new request be accepted while the last result waits
// synchronous active-low reset: config registers to their defaults, fan stopped, no hold, start time 0
`timescale 1ns / 1ps
`default_nettype none

module fan_curve_hysteresis_controller (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_s_tvalid,
    output logic                                 o_s_tready,
    // skin_temp[11:0], plate_temp[23:12], now_ms[55:24]
    input  logic [fchc_pkg::S_DATA_W-1:0]        i_s_tdata,
    // temps_ok[0]
    input  logic                                 i_s_tuser,
    output logic                                 o_m_tvalid,
    input  logic                                 i_m_tready,
    // fan_duty[6:0], fan_running[7], throttle_warn[8], zeros above
    output logic [fchc_pkg::M_DATA_W-1:0]        o_m_tdata,
    // data_fault[0]
    output logic                                 o_m_tuser,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [fchc_pkg::CFG_ADDR_W-1:0]      i_cfg_addr,
    input  logic [fchc_pkg::CFG_DATA_W-1:0]      i_cfg_data
);
    import fchc_pkg::*;

    t_cfg             r_cfg;
    logic             r_out_valid;
    t_result          r_out;
    logic [OP_W-1:0]  op;
    t_dp_stat         dp_stat;
    t_seq_stat        seq_stat;
    t_result          result;
    logic             accept;
    logic             out_free;
    logic             push;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.off_temp      <= OFF_TEMP_RST;
            r_cfg.on_temp       <= ON_TEMP_RST;
            r_cfg.full_temp     <= FULL_TEMP_RST;
            r_cfg.throttle_temp <= THROTTLE_TEMP_RST;
            r_cfg.floor_duty    <= FLOOR_DUTY_RST;
            r_cfg.ceiling_duty  <= CEILING_DUTY_RST;
            r_cfg.min_run_ms    <= MIN_RUN_MS_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_addr)
                REG_OFF_TEMP:      r_cfg.off_temp      <= i_cfg_data[TEMP_W-1:0];
                REG_ON_TEMP:       r_cfg.on_temp       <= i_cfg_data[TEMP_W-1:0];
                REG_FULL_TEMP:     r_cfg.full_temp     <= i_cfg_data[TEMP_W-1:0];
                REG_THROTTLE_TEMP: r_cfg.throttle_temp <= i_cfg_data[TEMP_W-1:0];
                REG_FLOOR_DUTY:    r_cfg.floor_duty    <= i_cfg_data[DUTY_W-1:0];
                REG_CEILING_DUTY:  r_cfg.ceiling_duty  <= i_cfg_data[DUTY_W-1:0];
                REG_MIN_RUN_MS:    r_cfg.min_run_ms    <= i_cfg_data[RUN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign o_s_tready = (op == OP_LOAD);
    assign accept     = i_s_tvalid && o_s_tready;
    assign out_free   = !r_out_valid || i_m_tready;
    assign push       = (op == OP_PUSH) && out_free;

    assign seq_stat.req      = i_s_tvalid;
    assign seq_stat.dp       = dp_stat;
    assign seq_stat.out_free = out_free;

    fchc_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (seq_stat),
        .o_op    (op)
    );

    fchc_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_op         (op),
        .i_load       (accept),
        .i_cfg        (r_cfg),
        .i_skin_temp  (i_s_tdata[TEMP_W-1:0]),
        .i_plate_temp (i_s_tdata[2*TEMP_W-1:TEMP_W]),
        .i_temps_ok   (i_s_tuser),
        .i_now_ms     (i_s_tdata[2*TEMP_W+TIME_W-1:2*TEMP_W]),
        .o_stat       (dp_stat),
        .o_result     (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (push) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_out <= result;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(M_DATA_W-PCT_W-2){1'b0}}, r_out.throttle_warn,
                         r_out.fan_running, r_out.fan_duty};
    assign o_m_tuser  = r_out.data_fault;

    // one request in flight: no acceptance right after another
    a_single_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("request accepted while previous one still in work");

    a_fault_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser) |->
            (o_m_tdata[PCT_W-1:0] == PCT_MAX && o_m_tdata[PCT_W] && !o_m_tdata[PCT_W+1]))
        else $error("fault result does not force full duty");

    a_stopped_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tdata[PCT_W]) |-> (o_m_tdata[PCT_W-1:0] == '0))
        else $error("stopped fan with nonzero duty");

    a_duty_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[PCT_W-1:0] <= PCT_MAX))
        else $error("duty above 100 percent");

    a_push_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> (!r_out_valid || i_m_tready))
        else $error("result overwritten before it was taken");

endmodule

`default_nettype wire
